// ===== rtl/tssa_pkg.sv =====
// Shared types and constants for the three-stack shared store.
package tssa_pkg;

   localparam int STACK_BITS    = 2;
   localparam int VALUE_BITS    = 32;
   localparam int STATUS_BITS   = 2;
   localparam int SLOT_BITS     = 10;
   localparam int MOVED_BITS    = 10;
   localparam int START_BITS    = 11;
   localparam int NUM_STACKS    = 3;
   localparam int MIN_START     = 3;
   localparam int MAX_ADDR_BITS = 16;

   // Division by three as a multiply by a reciprocal, exact below two to the DIV3_SHIFT.
   localparam int DIV3_MUL   = 43691;
   localparam int DIV3_SHIFT = 17;

   localparam logic [STACK_BITS-1:0] FIRST_STACK = 2'd0;
   localparam logic [STACK_BITS-1:0] MID_STACK   = 2'd1;
   localparam logic [STACK_BITS-1:0] LAST_STACK  = 2'd2;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_PUSHED    = 2'd0,
      STATUS_BAD_INDEX = 2'd1,
      STATUS_NO_ROOM   = 2'd2
   } status_type;

   typedef struct packed {
      logic                     wr;
      logic                     shift;
      logic [MAX_ADDR_BITS-1:0] slot;
      logic [MAX_ADDR_BITS-1:0] base;
   } cell_cmd_type;

endpackage

// ===== rtl/tssa_req_if.sv =====
// Push request channel: stack index and value with a valid/ready handshake.
interface tssa_req_if import tssa_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic [STACK_BITS-1:0]         stack_index;
   logic signed [VALUE_BITS-1:0]  value;

   modport source (output valid, stack_index, value, input ready);
   modport sink (input valid, stack_index, value, output ready);
endinterface

// ===== rtl/tssa_rsp_if.sv =====
// Push response channel: status, slot and moved count with a valid/ready handshake.
interface tssa_rsp_if import tssa_pkg::*; ();
   logic                  valid;
   logic                  ready;
   status_type            status;
   logic [SLOT_BITS-1:0]  slot;
   logic [MOVED_BITS-1:0] moved_count;

   modport source (output valid, status, slot, moved_count, input ready);
   modport sink (input valid, status, slot, moved_count, output ready);
endinterface

// ===== rtl/tssa_cell.sv =====
// One word of the store: takes a pushed word or its lower neighbour's word.
module tssa_cell import tssa_pkg::*; #(
   parameter int INDEX     = 0,
   parameter int WORD_BITS = 32
) (
   input  logic                 clock,
   input  cell_cmd_type         cmd,
   input  logic [WORD_BITS-1:0] cmd_word,
   input  logic [WORD_BITS-1:0] prev_word,
   output logic [WORD_BITS-1:0] word
);

   localparam logic [MAX_ADDR_BITS-1:0] SELF     = MAX_ADDR_BITS'(INDEX);
   localparam logic [MAX_ADDR_BITS-1:0] PREV     = MAX_ADDR_BITS'((INDEX > 0) ? INDEX - 1 : 0);
   localparam logic                     HAS_PREV = (INDEX > 0);

   logic [WORD_BITS-1:0] word_ff;
   logic [WORD_BITS-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      priority if (cmd.wr && (cmd.slot == SELF)) begin
         word_in = cmd_word;
      end else if (cmd.shift && HAS_PREV && (PREV >= cmd.base)) begin
         word_in = prev_word;
      end else begin
         word_in = word_ff;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

// ===== rtl/tssa_ctrl.sv =====
// Region bookkeeping, push decisions, response register and the command to the cell row.
module tssa_ctrl import tssa_pkg::*; #(
   parameter int CAPACITY  = 1024,
   parameter int WORD_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [START_BITS-1:0] csr_wdata,
   tssa_req_if.sink              req_chan,
   tssa_rsp_if.source            rsp_chan,
   output cell_cmd_type          cmd,
   output logic [WORD_BITS-1:0]  cmd_word
);

   localparam int ADDR_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int USED_BITS = ADDR_BITS + 1;
   localparam int SIZE_BITS = (USED_BITS > START_BITS) ? USED_BITS : START_BITS;
   localparam int PROD_BITS = USED_BITS + DIV3_SHIFT;

   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [USED_BITS-1:0] used_type;

   addr_type floor_ff [NUM_STACKS];
   addr_type floor_in [NUM_STACKS];
   addr_type ceil_ff [NUM_STACKS];
   addr_type ceil_in [NUM_STACKS];
   used_type next_ff [NUM_STACKS];
   used_type next_in [NUM_STACKS];
   used_type used_ff;
   used_type used_in;

   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   logic [SLOT_BITS-1:0]  rsp_slot_ff;
   logic [MOVED_BITS-1:0] rsp_moved_ff;
   cell_cmd_type          cmd_ff;
   cell_cmd_type          cmd_in;
   logic [WORD_BITS-1:0]  word_ff;

   logic [SIZE_BITS-1:0]  size_raw;
   logic [SIZE_BITS-1:0]  size_sat;
   used_type              size_n;
   logic [PROD_BITS-1:0]  size_prod;
   addr_type              share;

   logic                  accept;
   logic                  valid_idx;
   logic [STACK_BITS-1:0] sel;
   used_type              sel_next;
   logic                  full;
   logic                  no_room;
   logic                  push_ok;
   used_type              count_mid;
   used_type              count_last;
   used_type              moved_sum;
   addr_type              shift_base;
   status_type            status_in;

   assign size_raw  = SIZE_BITS'(csr_wdata);
   assign size_n    = USED_BITS'(size_sat);
   assign size_prod = PROD_BITS'(size_n) * PROD_BITS'(DIV3_MUL);
   assign share     = ADDR_BITS'(size_prod >> DIV3_SHIFT);

   always_comb begin
      priority if (reset) begin
         size_sat = SIZE_BITS'(MIN_START);
      end else if (size_raw < SIZE_BITS'(MIN_START)) begin
         size_sat = SIZE_BITS'(MIN_START);
      end else if (size_raw > SIZE_BITS'(CAPACITY)) begin
         size_sat = SIZE_BITS'(CAPACITY);
      end else begin
         size_sat = size_raw;
      end
   end

   assign accept    = req_chan.valid && req_chan.ready;
   assign valid_idx = (req_chan.stack_index <= LAST_STACK);
   assign sel       = valid_idx ? req_chan.stack_index : FIRST_STACK;
   assign sel_next  = next_ff[sel];
   assign full      = (sel_next == ({1'b0, ceil_ff[sel]} + USED_BITS'(1)));
   assign no_room   = full && (used_ff == USED_BITS'(CAPACITY));
   assign push_ok   = valid_idx && !no_room;

   assign count_mid  = next_ff[1] - {1'b0, floor_ff[1]};
   assign count_last = next_ff[2] - {1'b0, floor_ff[2]};

   always_comb begin
      unique case (sel)
         FIRST_STACK: begin
            moved_sum  = count_mid + count_last;
            shift_base = floor_ff[1];
         end
         MID_STACK: begin
            moved_sum  = count_last;
            shift_base = floor_ff[2];
         end
         default: begin
            moved_sum  = '0;
            shift_base = floor_ff[2];
         end
      endcase
   end

   always_comb begin
      priority if (!valid_idx) begin
         status_in = STATUS_BAD_INDEX;
      end else if (no_room) begin
         status_in = STATUS_NO_ROOM;
      end else begin
         status_in = STATUS_PUSHED;
      end
   end

   always_comb begin
      floor_in = floor_ff;
      ceil_in  = ceil_ff;
      next_in  = next_ff;
      used_in  = used_ff;
      priority if (reset || csr_we) begin
         floor_in[0] = '0;
         floor_in[1] = share;
         floor_in[2] = share << 1;
         ceil_in[0]  = share - ADDR_BITS'(1);
         ceil_in[1]  = (share << 1) - ADDR_BITS'(1);
         ceil_in[2]  = ADDR_BITS'(size_n - USED_BITS'(1));
         next_in[0]  = '0;
         next_in[1]  = {1'b0, share};
         next_in[2]  = {1'b0, share << 1};
         used_in     = size_n;
      end else if (accept && push_ok) begin
         if (full) begin
            used_in = used_ff + USED_BITS'(1);
            for (int i = 0; i < NUM_STACKS; i++) begin
               if (STACK_BITS'(i) > sel) begin
                  floor_in[i] = floor_ff[i] + ADDR_BITS'(1);
                  ceil_in[i]  = ceil_ff[i] + ADDR_BITS'(1);
                  next_in[i]  = next_ff[i] + USED_BITS'(1);
               end
            end
            ceil_in[sel] = ceil_ff[sel] + ADDR_BITS'(1);
         end
         next_in[sel] = next_ff[sel] + USED_BITS'(1);
      end else begin
         used_in = used_ff;
      end
   end

   always_comb begin
      cmd_in.wr    = accept && push_ok;
      cmd_in.shift = accept && push_ok && full && (sel != LAST_STACK);
      cmd_in.slot  = MAX_ADDR_BITS'(sel_next);
      cmd_in.base  = MAX_ADDR_BITS'(shift_base);
   end

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      floor_ff <= floor_in;
      ceil_ff  <= ceil_in;
      next_ff  <= next_in;
      used_ff  <= used_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cmd_ff       <= '0;
      end else begin
         cmd_ff <= cmd_in;
         if (req_chan.ready) begin
            rsp_valid_ff <= req_chan.valid;
         end
      end
      if (accept) begin
         rsp_status_ff <= status_in;
         rsp_slot_ff   <= push_ok ? SLOT_BITS'(sel_next) : '0;
         rsp_moved_ff  <= (push_ok && full) ? MOVED_BITS'(moved_sum) : '0;
         word_ff       <= WORD_BITS'($unsigned(req_chan.value));
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.slot        = rsp_slot_ff;
   assign rsp_chan.moved_count = rsp_moved_ff;
   assign cmd                  = cmd_ff;
   assign cmd_word             = word_ff;

   // The first region always starts at the bottom of the store.
   a_floor_zero: assert property (@(posedge clock) disable iff (reset)
      floor_ff[0] == '0)
      else $error("first region floor has moved");

   // Regions stay contiguous and the last one ends at the used size.
   a_contiguous: assert property (@(posedge clock) disable iff (reset)
      (({1'b0, ceil_ff[0]} + USED_BITS'(1)) == {1'b0, floor_ff[1]}) &&
      (({1'b0, ceil_ff[1]} + USED_BITS'(1)) == {1'b0, floor_ff[2]}) &&
      (({1'b0, ceil_ff[2]} + USED_BITS'(1)) == used_ff))
      else $error("regions are not contiguous");

   a_tops_in_region: assert property (@(posedge clock) disable iff (reset)
      (next_ff[0] <= {1'b0, ceil_ff[0]} + USED_BITS'(1)) &&
      (next_ff[1] >= {1'b0, floor_ff[1]}) &&
      (next_ff[1] <= {1'b0, ceil_ff[1]} + USED_BITS'(1)) &&
      (next_ff[2] >= {1'b0, floor_ff[2]}) &&
      (next_ff[2] <= {1'b0, ceil_ff[2]} + USED_BITS'(1)))
      else $error("stack top outside its region");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != STATUS_PUSHED) |->
         (rsp_slot_ff == '0) && (rsp_moved_ff == '0))
      else $error("rejected push reports a slot or moved count");

   a_shift_writes: assert property (@(posedge clock) disable iff (reset)
      cmd_ff.shift |-> cmd_ff.wr && (cmd_ff.slot < cmd_ff.base + MAX_ADDR_BITS'(1)))
      else $error("shift without a write below the shifted block");

endmodule

// ===== rtl/three_stacks_shared_array_push.sv =====
// Top level of three stacks sharing one word store, built as a row of word cells.
//
// Each push is transferred when the result register is empty or being emptied, and its
// result stands in that register from the next cycle until it is transferred, so a push
// may be transferred in every cycle while the response side takes each result. A push
// into a full region moves every higher stack up by one word at once, as each word
// cell takes its lower neighbour's word in parallel; the shift and the pushed word reach
// the cell row in the cycle after the transfer. The user must write the start size
// register only while no push is in flight; the block itself does not enforce this.
// Writing it empties all three stacks. The store is not cleared after reset.
module three_stacks_shared_array_push import tssa_pkg::*; #(
   parameter int CAPACITY  = 1024,
   parameter int WORD_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [START_BITS-1:0] csr_wdata,
   tssa_req_if.sink              req_chan,
   tssa_rsp_if.source            rsp_chan
);

   cell_cmd_type         cmd;
   logic [WORD_BITS-1:0] cmd_word;
   logic [WORD_BITS-1:0] cell_word [CAPACITY];

   tssa_ctrl #(
      .CAPACITY  (CAPACITY),
      .WORD_BITS (WORD_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .cmd       (cmd),
      .cmd_word  (cmd_word)
   );

   for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
      logic [WORD_BITS-1:0] prev_word;

      if (j == 0) begin : g_first
         assign prev_word = cell_word[0];
      end else begin : g_rest
         assign prev_word = cell_word[j-1];
      end

      tssa_cell #(
         .INDEX     (j),
         .WORD_BITS (WORD_BITS)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .cmd_word  (cmd_word),
         .prev_word (prev_word),
         .word      (cell_word[j])
      );
   end

endmodule
